>>> sv/lcs_pkg.sv
// Shared types and constants for the LED cue sequencer.
// No dependencies; imported by the top level and its checker.
package lcs_pkg;

    // Reset values of the configuration registers and default half periods
    localparam int DEF_BLINK_HALF_MS = 250;
    localparam int DEF_RED_HALF_MS   = 125;
    localparam logic [15:0] RST_RED_DUR_MS   = 16'd3000;
    localparam logic [15:0] RST_GREEN_DUR_MS = 16'd1000;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_RED_DUR   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_DUR = 1'd1;

    localparam logic [7:0] LEVEL_ON  = 8'hFF;
    localparam logic [7:0] LEVEL_OFF = 8'h00;

    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_HOLD_BEGIN = 2'd1,
        REQ_HOLD_END   = 2'd2,
        REQ_FACTORY    = 2'd3
    } t_req;

    // Cue as it appears on the result word
    typedef enum logic [1:0] {
        CODE_IDLE  = 2'd0,
        CODE_BLINK = 2'd1,
        CODE_RED   = 2'd2,
        CODE_GREEN = 2'd3
    } t_cue_code;

    // Cue state machine, one-hot
    typedef enum logic [3:0] {
        CUE_IDLE  = 4'b0001,
        CUE_BLINK = 4'b0010,
        CUE_RED   = 4'b0100,
        CUE_GREEN = 4'b1000
    } t_cue;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] tick_ms;
    } t_in_word;

    typedef struct packed {
        logic [1:0] cue_state;
        logic       active;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_word;

endpackage

>>> sv/led_cue_sequencer.sv
// LED cue sequencer: cue state machine plus colour rendering pipeline.
// Depends on lcs_pkg (word types, cue codes, register indexes).
//
// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one event word:
//   a request type and a millisecond timestamp that wraps modulo 2^32. Output
//   channel (o_out_valid / i_out_stall / o_out_word) returns exactly one result
//   word per event: new cue, active flag and the RGB level for every LED.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 red duration, 1 green duration); write only while the block is idle.
// Timing
//   Five register stages: input register, state update, reciprocal multiply,
//   remainder multiply, output register. Throughput is one word per cycle
//   while the output is not stalled. The blink and red phases need elapsed /
//   half-period, done as a multiply by a constant reciprocal, a
//   back-multiply and a single compare-and-correct step.
// Reset and stall
//   Synchronous reset empties the pipe, returns the cue to idle, clears the
//   entry time and loads the default durations. A stalled output holds the
//   whole pipe: o_in_stall rises with i_out_stall while a result waits, and
//   the cue state advances only when its word moves on.
module led_cue_sequencer
    import lcs_pkg::*;
#(
    parameter int BLINK_HALF_MS = DEF_BLINK_HALF_MS,
    parameter int RED_HALF_MS   = DEF_RED_HALF_MS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Half periods: zero is taken as one
    localparam int BLINK_H = (BLINK_HALF_MS == 0) ? 1 : BLINK_HALF_MS;
    localparam int RED_H   = (RED_HALF_MS == 0) ? 1 : RED_HALF_MS;
    localparam logic [15:0] BLINK_H16 = 16'(BLINK_H);
    localparam logic [15:0] RED_H16   = 16'(RED_H);
    // floor(2^32 / H): estimate undershoots the true quotient by at most one
    localparam logic [64:0] ONE_SHL32 = 65'd1 << 32;
    localparam logic [32:0] RECIP_BLINK = 33'(ONE_SHL32 / 65'(BLINK_H));
    localparam logic [32:0] RECIP_RED   = 33'(ONE_SHL32 / 65'(RED_H));

    // Configuration
    logic [15:0] r_red_dur;
    logic [15:0] r_green_dur;

    // Cue state
    t_cue        r_cue,   n_cue;
    logic [31:0] r_entry, n_entry;

    // Pipe
    logic        en;
    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    t_in_word    r_s1;

    logic [31:0] r_s2_el;
    t_cue_code   r_s2_code;
    logic        r_s2_red;

    logic [31:0] r_s3_el;
    logic [31:0] r_s3_q;
    t_cue_code   r_s3_code;
    logic        r_s3_red;

    logic [31:0] r_s4_el;
    logic [31:0] r_s4_qh;
    logic        r_s4_q0;
    t_cue_code   r_s4_code;
    logic        r_s4_red;

    t_out_word   r_out;

    // Stage-one combinational signals
    t_req        w_req;
    logic [31:0] w_now;
    logic [31:0] w_el_old;
    logic        w_go;
    t_cue_code   w_code;

    // Later stages
    logic [32:0] w_recip;
    logic [64:0] w_prod;
    logic [15:0] w_h3;
    logic [47:0] w_qh;
    logic [15:0] w_h4;
    logic [31:0] w_rem;
    logic        w_step;
    logic        w_phase_on;
    t_out_word   w_out;

    // Advance the whole pipe unless a result waits on a stalled receiver
    assign en          = !r_v5 || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_v5;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_dur   <= RST_RED_DUR_MS;
            r_green_dur <= RST_GREEN_DUR_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RED_DUR:   r_red_dur   <= i_cfg_data;
                REG_GREEN_DUR: r_green_dur <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Cue update for the word in the input register
    always_comb begin
        w_req    = t_req'(r_s1.req_type);
        w_now    = r_s1.tick_ms;
        w_el_old = w_now - r_entry;
        n_cue    = r_cue;
        n_entry  = r_entry;
        w_go     = 1'b0;
        if (w_req == REQ_FACTORY) begin
            n_cue = CUE_RED;
            w_go  = 1'b1;
        end else begin
            case (r_cue)
                CUE_IDLE: begin
                    if (w_req == REQ_HOLD_BEGIN) begin
                        n_cue = CUE_BLINK;
                        w_go  = 1'b1;
                    end
                end
                CUE_BLINK: begin
                    if (w_req == REQ_HOLD_END) begin
                        n_cue = CUE_IDLE;
                        w_go  = 1'b1;
                    end
                end
                CUE_RED: begin
                    if (w_req == REQ_TICK && w_el_old >= {16'd0, r_red_dur}) begin
                        n_cue = CUE_GREEN;
                        w_go  = 1'b1;
                    end
                end
                CUE_GREEN: begin
                    if (w_req == REQ_TICK && w_el_old >= {16'd0, r_green_dur}) begin
                        n_cue = CUE_IDLE;
                        w_go  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (w_go) begin
            n_entry = w_now;
        end
        case (n_cue)
            CUE_BLINK: w_code = CODE_BLINK;
            CUE_RED:   w_code = CODE_RED;
            CUE_GREEN: w_code = CODE_GREEN;
            default:   w_code = CODE_IDLE;
        endcase
    end

    // Quotient estimate: (elapsed * recip) >> 32
    assign w_recip = r_s2_red ? RECIP_RED : RECIP_BLINK;
    assign w_prod  = {33'd0, r_s2_el} * {32'd0, w_recip};

    // Back-multiply; low 32 bits suffice as the remainder is small
    assign w_h3 = r_s3_red ? RED_H16 : BLINK_H16;
    assign w_qh = {16'd0, r_s3_q} * {32'd0, w_h3};

    // Correct the estimate by one and take the quotient parity
    always_comb begin
        w_h4       = r_s4_red ? RED_H16 : BLINK_H16;
        w_rem      = r_s4_el - r_s4_qh;
        w_step     = w_rem >= {16'd0, w_h4};
        w_phase_on = !(r_s4_q0 ^ w_step);
        w_out.cue_state = r_s4_code;
        w_out.active    = (r_s4_code != CODE_IDLE);
        w_out.red       = LEVEL_OFF;
        w_out.green     = LEVEL_OFF;
        w_out.blue      = LEVEL_OFF;
        case (r_s4_code)
            CODE_BLINK: w_out.blue  = w_phase_on ? LEVEL_ON : LEVEL_OFF;
            CODE_RED:   w_out.red   = w_phase_on ? LEVEL_ON : LEVEL_OFF;
            CODE_GREEN: w_out.green = LEVEL_ON;
            default: ;
        endcase
    end

    // Control: valid bits and cue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_cue   <= CUE_IDLE;
            r_entry <= 32'd0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (r_v1) begin
                r_cue   <= n_cue;
                r_entry <= n_entry;
            end
        end
    end

    // Payload: no reset, move with the pipe
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= i_in_word;

            // Entering a state now means zero elapsed time
            r_s2_el   <= w_go ? 32'd0 : w_el_old;
            r_s2_code <= w_code;
            r_s2_red  <= (n_cue == CUE_RED);

            r_s3_el   <= r_s2_el;
            r_s3_q    <= w_prod[63:32];
            r_s3_code <= r_s2_code;
            r_s3_red  <= r_s2_red;

            r_s4_el   <= r_s3_el;
            r_s4_qh   <= w_qh[31:0];
            r_s4_q0   <= r_s3_q[0];
            r_s4_code <= r_s3_code;
            r_s4_red  <= r_s3_red;

            r_out <= w_out;
        end
    end

endmodule

>>> sv/lcs_checker.sv
// Port-level checker for the LED cue sequencer, bound to the top level.
// Depends on lcs_pkg for word types and cue codes.
module lcs_checker
    import lcs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_word              i_in_word,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_word             o_out_word,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed or dropped");

    // Reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

    // Active flag must agree with the cue, and idle and green cues with their colours
    a_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.active == (o_out_word.cue_state != CODE_IDLE)))
        else $error("active flag disagrees with cue");

    a_idle_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.cue_state == CODE_IDLE |->
            o_out_word.red == LEVEL_OFF && o_out_word.green == LEVEL_OFF
            && o_out_word.blue == LEVEL_OFF)
        else $error("idle cue shows a colour");

    a_green_solid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.cue_state == CODE_GREEN |->
            o_out_word.red == LEVEL_OFF && o_out_word.green == LEVEL_ON
            && o_out_word.blue == LEVEL_OFF)
        else $error("green cue is not solid green");

endmodule

bind led_cue_sequencer lcs_checker u_lcs_checker (.*);
